// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority stack
// Request and status codes, widths and the command broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W           = 32;
  localparam int FILL_W           = 5;
  localparam int STATUS_W         = 2;
  localparam int CAPACITY_DEFAULT = 16;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;

  // command seen by every cell in the same cycle
  typedef struct packed {
    logic                     push;   // insert value, store not full
    logic                     pop;    // remove top, store not empty
    logic signed [DATA_W-1:0] value;  // value being inserted
  } cell_cmd_t;

endpackage

// ===== rtl/core/sorted_priority_stack_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_stack_core: bounded stack kept in descending order
// Chain of CAPACITY cells, largest value in cell 0; push or pop per transfer.
// ----------------------------------------------------------------------------
// On each accepted request every cell compares its value with the pushed
// value in parallel and shifts one place toward or away from the top in the
// same cycle, so a new request is taken every cycle while the result
// register is free or being drained. The result register sits between the
// chain and the output channel, so result valid rises in the cycle after the
// input transfer. A push to a full stack is dropped with status 1, a pop
// from an empty stack returns status 2 and zero. Stored slots need no
// clearing after reset; only the fill count and the result valid are reset.
// ----------------------------------------------------------------------------
module sorted_priority_stack_core #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [spq_pkg::DATA_W-1:0]   push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spq_pkg::STATUS_W-1:0]        status,
  output logic signed [spq_pkg::DATA_W-1:0]   popped_value,
  output logic signed [spq_pkg::DATA_W-1:0]   top_value,
  output logic                                is_empty,
  output logic [spq_pkg::FILL_W-1:0]          fill_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  cell_cmd_t                 cmd;
  logic [STATUS_W-1:0]       status_next;

  logic                      occ     [CAPACITY];
  logic                      gt      [CAPACITY];
  logic signed [DATA_W-1:0]  val     [CAPACITY];
  logic signed [DATA_W-1:0]  val_nxt [CAPACITY];

  // input transfer while the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  // command broadcast to the chain
  always_comb begin
    cmd.push  = accept && (req_type == REQ_PUSH) && !full;
    cmd.pop   = accept && (req_type == REQ_POP) && !empty;
    cmd.value = push_value;
  end

  // count update and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (req_type == REQ_PUSH) begin
      if (full) status_next = ST_PUSH_FULL;
    end else begin
      if (empty) status_next = ST_POP_EMPTY;
    end
    if (cmd.push) count_next = count + CNT_W'(1);
    else if (cmd.pop) count_next = count - CNT_W'(1);
  end

  // cell chain, cell 0 holds the top
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_gt_w;
    logic signed [DATA_W-1:0] prev_val_w;
    logic signed [DATA_W-1:0] next_val_w;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_gt_w  = 1'b1;
      assign prev_val_w = '0;
    end else begin : g_body
      assign prev_gt_w  = gt[i-1];
      assign prev_val_w = val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val_w = '0;
    end else begin : g_inner
      assign next_val_w = val[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occupied (occ[i]),
      .prev_gt  (prev_gt_w),
      .prev_val (prev_val_w),
      .next_val (next_val_w),
      .gt       (gt[i]),
      .val      (val[i]),
      .val_next (val_nxt[i])
    );
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= cmd.pop ? val[0] : '0;
      top_value    <= (count_next == '0) ? '0 : val_nxt[0];
      is_empty     <= (count_next == '0);
      fill_count   <= FILL_W'(count_next);
    end
  end

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value; on a push it keeps, takes the new value or takes its
// upper neighbor's value, on a pop it takes its lower neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_cmd_t               cmd,
  input  logic                             occupied,
  input  logic                             prev_gt,
  input  logic signed [spq_pkg::DATA_W-1:0] prev_val,
  input  logic signed [spq_pkg::DATA_W-1:0] next_val,
  output logic                             gt,
  output logic signed [spq_pkg::DATA_W-1:0] val,
  output logic signed [spq_pkg::DATA_W-1:0] val_next
);
  import spq_pkg::*;

  // stored value strictly above the one being inserted
  assign gt = occupied && (val > cmd.value);

  // select the value this slot holds after the transfer
  always_comb begin
    val_next = val;
    if (cmd.push) begin
      if (!gt) begin
        val_next = prev_gt ? cmd.value : prev_val;
      end
    end else if (cmd.pop) begin
      val_next = next_val;
    end
  end

  // slot storage, no reset needed
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/core/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority stack
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [spq_pkg::STATUS_W-1:0]      status,
  input logic signed [spq_pkg::DATA_W-1:0] popped_value,
  input logic signed [spq_pkg::DATA_W-1:0] top_value,
  input logic                              is_empty,
  input logic [spq_pkg::FILL_W-1:0]        fill_count
);
  import spq_pkg::*;

  // result channel is quiet right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // empty result reports no top and zero count
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (top_value == '0) && (fill_count == '0))
    else $error("empty result with nonzero top or count");

  // failed pop returns zero and reports empty
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_POP_EMPTY) |-> (popped_value == '0) && is_empty)
    else $error("pop on empty with bad fields");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_PUSH_FULL)
                  || (status == ST_POP_EMPTY))
    else $error("undefined status code");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
                                && $stable(top_value) && $stable(fill_count))
    else $error("stalled result changed");

endmodule

bind sorted_priority_stack_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .popped_value (popped_value),
  .top_value    (top_value),
  .is_empty     (is_empty),
  .fill_count   (fill_count)
);
